### rtl/igad_pkg.sv
package igad_pkg;

  // Field widths
  localparam int unsigned RowW   = 18;
  localparam int unsigned PosW   = 13;
  localparam int unsigned DimW   = 13;
  localparam int unsigned KernW  = 5;
  localparam int unsigned StrW   = 5;
  localparam int unsigned PadW   = 4;
  localparam int unsigned IndexW = 34;

  // Reciprocal divide: exact for RowW-bit numerators and divisors below 2**KernW
  localparam int unsigned RecipShift = RowW + KernW;
  localparam int unsigned RecipW     = RecipShift + 1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageHeight = 3'd0,
    CfgImageWidth  = 3'd1,
    CfgKernelRows  = 3'd2,
    CfgKernelCols  = 3'd3,
    CfgRowStride   = 3'd4,
    CfgColStride   = 3'd5,
    CfgPadTop      = 3'd6,
    CfgPadLeft     = 3'd7
  } cfg_index_e;

  typedef logic [RowW-1:0]  row_t;
  typedef logic [KernW-1:0] kern_t;

endpackage

### rtl/igad_divmod.sv
module igad_divmod import igad_pkg::*; (
  input  logic  clk_i,
  input  logic  en_a_i,
  input  logic  en_b_i,
  input  row_t  num_i,
  input  kern_t div_i,
  output row_t  quo_o,
  output kern_t rem_o
);

  localparam int unsigned NumDiv = 2 ** KernW;
  localparam int unsigned ProdAW = RowW + RecipW;
  localparam int unsigned BackW  = RowW + KernW;

  logic [RecipW-1:0] recip_tab [NumDiv];

  for (genvar d = 0; d < NumDiv; d++) begin : g_recip
    localparam longint unsigned Val =
      (d == 0) ? 64'd0 : ((64'd1 << RecipShift) + 64'(d) - 64'd1) / 64'(d);
    assign recip_tab[d] = RecipW'(Val);
  end

  logic [ProdAW-1:0] prod_a;
  row_t              quo_a_d, quo_a_q, num_a_q, quo_b_q;
  kern_t             div_a_q, rem_b_d, rem_b_q;
  logic [BackW-1:0]  back_b;

  // Stage A: quotient by reciprocal multiply
  assign prod_a  = ProdAW'(num_i) * ProdAW'(recip_tab[div_i]);
  assign quo_a_d = prod_a[RecipShift +: RowW];

  always_ff @(posedge clk_i) begin
    if (en_a_i) begin
      quo_a_q <= quo_a_d;
      num_a_q <= num_i;
      div_a_q <= div_i;
    end
  end

  // Stage B: remainder from quotient
  assign back_b  = BackW'(quo_a_q) * BackW'(div_a_q);
  assign rem_b_d = KernW'(num_a_q - back_b[RowW-1:0]);

  always_ff @(posedge clk_i) begin
    if (en_b_i) begin
      quo_b_q <= quo_a_q;
      rem_b_q <= rem_b_d;
    end
  end

  assign quo_o = quo_b_q;
  assign rem_o = rem_b_q;

endmodule

### rtl/im2col_gather_address.sv
// Gather-address generator for NCHW im2col lowering.
// Request channel: in_valid_i/in_ready_o with patch_row_i, out_y_i, out_x_i.
// Result channel: out_valid_o/out_ready_i with source_index_o, is_padding_o.
// Each request yields one result: the flat image index of the tap, or
// is_padding_o high with source_index_o zero when the tap is off the image.
// Throughput is one request per cycle while out_ready_i stays high; the
// eight register stages run as one pipeline whose divider stages hold a
// reciprocal multiply for the kernel split.
// Configuration goes through cfg_we_i/cfg_index_i/cfg_data_i, one register per
// cycle, and must only change while no request is in flight.
// Reset clears all stage valids and loads the configuration defaults: image
// and kernel 1x1, strides 1, no padding.
// When out_ready_i is low each stage holds once its successor is full; empty
// stages keep filling, so in_ready_o drops only when all eight stages are full.
module im2col_gather_address import igad_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = 1024,
  parameter int unsigned MAX_DIM      = 4096,
  parameter int unsigned MAX_KERNEL   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DimW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RowW-1:0]     patch_row_i,
  input  logic [PosW-1:0]     out_y_i,
  input  logic [PosW-1:0]     out_x_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [IndexW-1:0]   source_index_o,
  output logic                is_padding_o
);

  localparam int unsigned NumStages = 8;
  localparam int unsigned ProdW     = PosW + StrW;
  localparam int unsigned TapW      = ProdW + 2;
  localparam int unsigned LinW      = RowW + DimW;
  localparam int unsigned ScaledW   = LinW + DimW;

  localparam logic [DimW-1:0] DimCap =
    (MAX_DIM > (2 ** DimW - 1)) ? {DimW{1'b1}} : DimW'(MAX_DIM);
  localparam kern_t KernCap =
    (MAX_KERNEL > (2 ** KernW - 1)) ? {KernW{1'b1}} : KernW'(MAX_KERNEL);

  // Configuration registers
  logic [DimW-1:0]  img_h_q, img_w_q;
  kern_t            kern_r_q, kern_c_q;
  logic [StrW-1:0]  stride_r_q, stride_c_q;
  logic [PadW-1:0]  pad_t_q, pad_l_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_h_q    <= DimW'(1);
      img_w_q    <= DimW'(1);
      kern_r_q   <= KernW'(1);
      kern_c_q   <= KernW'(1);
      stride_r_q <= StrW'(1);
      stride_c_q <= StrW'(1);
      pad_t_q    <= '0;
      pad_l_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgImageHeight: img_h_q    <= cfg_data_i;
        CfgImageWidth:  img_w_q    <= cfg_data_i;
        CfgKernelRows:  kern_r_q   <= cfg_data_i[KernW-1:0];
        CfgKernelCols:  kern_c_q   <= cfg_data_i[KernW-1:0];
        CfgRowStride:   stride_r_q <= cfg_data_i[StrW-1:0];
        CfgColStride:   stride_c_q <= cfg_data_i[StrW-1:0];
        CfgPadTop:      pad_t_q    <= cfg_data_i[PadW-1:0];
        CfgPadLeft:     pad_l_q    <= cfg_data_i[PadW-1:0];
        default: ;
      endcase
    end
  end

  // Clamped geometry
  kern_t           kr, kc;
  logic [DimW-1:0] ih, iw;

  assign kr = (kern_r_q == '0) ? KernW'(1) : ((kern_r_q > KernCap) ? KernCap : kern_r_q);
  assign kc = (kern_c_q == '0) ? KernW'(1) : ((kern_c_q > KernCap) ? KernCap : kern_c_q);
  assign ih = (img_h_q > DimCap) ? DimCap : img_h_q;
  assign iw = (img_w_q > DimCap) ? DimCap : img_w_q;

  // Pipeline control: a stage advances when empty or when its successor advances
  logic [NumStages:1]   valid_q;
  logic [NumStages:1]   en;
  logic [NumStages-1:0] valid_in;

  assign valid_in = {valid_q[NumStages-1:1], in_valid_i};

  always_comb begin
    en[NumStages] = !valid_q[NumStages] || out_ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = valid_q[NumStages];

  // Stages 1-2: split patch row by kernel columns
  row_t  q1;
  kern_t kx2;

  igad_divmod u_div_col (
    .clk_i  (clk_i),
    .en_a_i (en[1]),
    .en_b_i (en[2]),
    .num_i  (patch_row_i),
    .div_i  (kc),
    .quo_o  (q1),
    .rem_o  (kx2)
  );

  // Stages 3-4: split by kernel rows into channel and kernel row
  row_t  ch4;
  kern_t ky4;

  igad_divmod u_div_row (
    .clk_i  (clk_i),
    .en_a_i (en[3]),
    .en_b_i (en[4]),
    .num_i  (q1),
    .div_i  (kr),
    .quo_o  (ch4),
    .rem_o  (ky4)
  );

  // Window origin products travel alongside the divider
  logic [ProdW-1:0] oy_d, ox_d;
  logic [ProdW-1:0] oy_q [1:4];
  logic [ProdW-1:0] ox_q [1:4];
  kern_t            kx3_q, kx4_q;

  assign oy_d = ProdW'(out_y_i) * ProdW'(stride_r_q);
  assign ox_d = ProdW'(out_x_i) * ProdW'(stride_c_q);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      oy_q[1] <= oy_d;
      ox_q[1] <= ox_d;
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        oy_q[k] <= oy_q[k-1];
        ox_q[k] <= ox_q[k-1];
      end
    end
    if (en[3]) kx3_q <= kx2;
    if (en[4]) kx4_q <= kx3_q;
  end

  // Stage 5: tap coordinates
  logic signed [TapW-1:0] ty_d, tx_d, ty5_q, tx5_q;
  row_t                   ch5_q;

  assign ty_d = $signed({2'b00, oy_q[4]}) + $signed({{(TapW-KernW){1'b0}}, ky4})
              - $signed({{(TapW-PadW){1'b0}}, pad_t_q});
  assign tx_d = $signed({2'b00, ox_q[4]}) + $signed({{(TapW-KernW){1'b0}}, kx4_q})
              - $signed({{(TapW-PadW){1'b0}}, pad_l_q});

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      ty5_q <= ty_d;
      tx5_q <= tx_d;
      ch5_q <= ch4;
    end
  end

  // Stage 6: bounds check and channel plane base
  logic            inside_d, pad6_q;
  logic [LinW-1:0] chih_d, chih6_q;
  logic [DimW-1:0] ty6_q, tx6_q;

  assign inside_d = (32'(ch5_q) < 32'(MAX_CHANNELS))
                 && !ty5_q[TapW-1] && (ty5_q[TapW-2:0] < (TapW-1)'(ih))
                 && !tx5_q[TapW-1] && (tx5_q[TapW-2:0] < (TapW-1)'(iw));
  assign chih_d   = LinW'(ch5_q) * LinW'(ih);

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      pad6_q  <= !inside_d;
      chih6_q <= chih_d;
      ty6_q   <= ty5_q[DimW-1:0];
      tx6_q   <= tx5_q[DimW-1:0];
    end
  end

  // Stage 7: row offset within the image
  logic [LinW-1:0] lin7_q;
  logic [DimW-1:0] tx7_q;
  logic            pad7_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      lin7_q <= chih6_q + LinW'(ty6_q);
      tx7_q  <= tx6_q;
      pad7_q <= pad6_q;
    end
  end

  // Stage 8: flat index, output register
  logic [ScaledW-1:0] scaled;
  logic [IndexW-1:0]  index_d, index_q;
  logic               pad8_q;

  assign scaled  = ScaledW'(lin7_q) * ScaledW'(iw);
  assign index_d = scaled[IndexW-1:0] + IndexW'(tx7_q);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      index_q <= pad7_q ? '0 : index_d;
      pad8_q  <= pad7_q;
    end
  end

  assign source_index_o = index_q;
  assign is_padding_o   = pad8_q;

endmodule

### bench/tb_top.sv
module tb_top;
  import igad_pkg::*;

  localparam int unsigned MaxChannels   = 1024;
  localparam int unsigned MaxDim        = 4096;
  localparam int unsigned MaxKernel     = 16;
  localparam int unsigned NumRegs       = 8;
  localparam int unsigned RandomPhases  = 12;
  localparam int unsigned PhaseRequests = 150;
  localparam int unsigned WatchdogLimit = 4000;

  typedef logic [PosW-1:0] pos_t;
  typedef logic [DimW-1:0] reg_set_t [NumRegs];

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              pad;
  } tap_t;

  typedef struct packed {
    int unsigned set;
    row_t        row;
    pos_t        y;
    pos_t        x;
    bit          typed;
    tap_t        want;
  } probe_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i    = '0;
  logic [DimW-1:0]    cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  row_t               patch_row_i    = '0;
  pos_t               out_y_i        = '0;
  pos_t               out_x_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [IndexW-1:0]  source_index_o;
  logic               is_padding_o;

  // Register copies as the block holds them
  logic [DimW-1:0]  img_h = 13'd1;
  logic [DimW-1:0]  img_w = 13'd1;
  kern_t            k_rows = 5'd1;
  kern_t            k_cols = 5'd1;
  logic [StrW-1:0]  stride_y = 5'd1;
  logic [StrW-1:0]  stride_x = 5'd1;
  logic [PadW-1:0]  pad_top = 4'd0;
  logic [PadW-1:0]  pad_left = 4'd0;

  tap_t        expected_taps [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  bit          req_up         = 1'b0;
  int unsigned active_set     = 0;

  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned stall_phase = 0;

  reg_set_t reg_sets [6] = '{
    '{13'd1,    13'd1,    13'd1,  13'd1,  13'd1,  13'd1,  13'd0,  13'd0},
    '{13'd32,   13'd40,   13'd3,  13'd3,  13'd2,  13'd2,  13'd1,  13'd1},
    '{13'd4096, 13'd4096, 13'd16, 13'd16, 13'd16, 13'd16, 13'd15, 13'd15},
    '{13'd8191, 13'd8191, 13'd31, 13'd31, 13'd31, 13'd31, 13'd15, 13'd15},
    '{13'd0,    13'd5,    13'd0,  13'd0,  13'd0,  13'd0,  13'd0,  13'd3},
    '{13'd6,    13'd7,    13'd0,  13'd0,  13'd0,  13'd0,  13'd0,  13'd0}
  };

  probe_t directed [23] = '{
    // reset registers: 1x1 image, so only channel taps at the origin land inside
    '{0, 18'd0,      13'd0,    13'd0,    1'b1, '{34'd0,    1'b0}},
    '{0, 18'd1023,   13'd0,    13'd0,    1'b1, '{34'd1023, 1'b0}},
    '{0, 18'd1024,   13'd0,    13'd0,    1'b1, '{34'd0,    1'b1}},
    '{0, 18'd0,      13'd1,    13'd0,    1'b1, '{34'd0,    1'b1}},
    '{0, 18'd0,      13'd0,    13'd1,    1'b1, '{34'd0,    1'b1}},
    '{0, 18'd262143, 13'd8191, 13'd8191, 1'b1, '{34'd0,    1'b1}},
    '{1, 18'd0,      13'd0,    13'd0,    1'b0, '{34'd0,    1'b0}},
    '{1, 18'd4,      13'd0,    13'd0,    1'b0, '{34'd0,    1'b0}},
    '{1, 18'd8,      13'd15,   13'd19,   1'b0, '{34'd0,    1'b0}},
    '{1, 18'd49,     13'd16,   13'd20,   1'b0, '{34'd0,    1'b0}},
    '{1, 18'd262143, 13'd0,    13'd0,    1'b0, '{34'd0,    1'b0}},
    '{1, 18'd17,     13'd8191, 13'd0,    1'b0, '{34'd0,    1'b0}},
    '{2, 18'd262143, 13'd255,  13'd255,  1'b0, '{34'd0,    1'b0}},
    '{2, 18'd0,      13'd0,    13'd0,    1'b0, '{34'd0,    1'b0}},
    '{2, 18'd255,    13'd1,    13'd1,    1'b0, '{34'd0,    1'b0}},
    '{3, 18'd262143, 13'd100,  13'd100,  1'b0, '{34'd0,    1'b0}},
    '{3, 18'd17,     13'd1,    13'd2,    1'b0, '{34'd0,    1'b0}},
    '{3, 18'd0,      13'd8191, 13'd8191, 1'b0, '{34'd0,    1'b0}},
    // zero image height: every tap is padding
    '{4, 18'd0,      13'd0,    13'd0,    1'b1, '{34'd0,    1'b1}},
    '{4, 18'd3,      13'd8191, 13'd8191, 1'b1, '{34'd0,    1'b1}},
    '{5, 18'd5,      13'd77,   13'd13,   1'b0, '{34'd0,    1'b0}},
    '{5, 18'd1023,   13'd8191, 13'd0,    1'b0, '{34'd0,    1'b0}},
    '{5, 18'd262143, 13'd1,    13'd1,    1'b0, '{34'd0,    1'b0}}
  };

  im2col_gather_address #(
    .MAX_CHANNELS(MaxChannels),
    .MAX_DIM     (MaxDim),
    .MAX_KERNEL  (MaxKernel)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .patch_row_i   (patch_row_i),
    .out_y_i       (out_y_i),
    .out_x_i       (out_x_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .source_index_o(source_index_o),
    .is_padding_o  (is_padding_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint effective_kernel(input kern_t k);
    if (k == 0) return 1;
    if (k > MaxKernel) return MaxKernel;
    return k;
  endfunction

  function automatic longint effective_dim(input logic [DimW-1:0] d);
    return (d > MaxDim) ? MaxDim : d;
  endfunction

  function automatic tap_t predict_tap(input row_t r, input pos_t y, input pos_t x);
    longint kr, kc, ih, iw, kx, ky, ch, ty, tx, idx, ys, xs, rs, cs, pt, pl;
    tap_t   t;
    kr = effective_kernel(k_rows);
    kc = effective_kernel(k_cols);
    ih = effective_dim(img_h);
    iw = effective_dim(img_w);
    ys = y;
    xs = x;
    rs = stride_y;
    cs = stride_x;
    pt = pad_top;
    pl = pad_left;
    kx = r % kc;
    ky = (r / kc) % kr;
    ch = r / kc / kr;
    ty = ys * rs - pt + ky;
    tx = xs * cs - pl + kx;
    if (ch < MaxChannels && ty >= 0 && ty < ih && tx >= 0 && tx < iw) begin
      idx = (ch * ih + ty) * iw + tx;
      t.index = idx[IndexW-1:0];
      t.pad   = 1'b0;
    end else begin
      t.index = '0;
      t.pad   = 1'b1;
    end
    return t;
  endfunction

  function automatic void apply_register(input cfg_index_e idx, input logic [DimW-1:0] v);
    case (idx)
      CfgImageHeight: img_h    = v;
      CfgImageWidth:  img_w    = v;
      CfgKernelRows:  k_rows   = v[KernW-1:0];
      CfgKernelCols:  k_cols   = v[KernW-1:0];
      CfgRowStride:   stride_y = v[StrW-1:0];
      CfgColStride:   stride_x = v[StrW-1:0];
      CfgPadTop:      pad_top  = v[PadW-1:0];
      CfgPadLeft:     pad_left = v[PadW-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [DimW-1:0] pick_value(input int unsigned lo, input int unsigned hi,
                                                 input int unsigned bits);
    case ($urandom_range(0, 9))
      0: return DimW'(lo);
      1: return DimW'(hi);
      2: return DimW'((1 << bits) - 1);
      3: return '0;
      4, 5, 6: return DimW'($urandom_range(lo, (hi < 40) ? hi : 40));
      default: return DimW'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input tap_t got, input tap_t want);
    $display("%0t: %s wrong: got index %0d pad %0b, want index %0d pad %0b",
             $time, what, got.index, got.pad, want.index, want.pad);
    mismatch_count++;
  endtask

  // Writes go out back to back; the block must hold no request while they land.
  task automatic load_registers(input reg_set_t vals);
    cfg_index_e idx;
    for (int i = 0; i < NumRegs; i++) begin
      idx = cfg_index_e'(i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      apply_register(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    if (req_up) begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
    end
    while (expected_taps.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_request(input row_t r, input pos_t y, input pos_t x, input bit typed,
                              input tap_t typed_tap);
    in_valid_i  <= 1'b1;
    patch_row_i <= r;
    out_y_i     <= y;
    out_x_i     <= x;
    req_up = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_taps.push_back(typed ? typed_tap : predict_tap(r, y, x));
  endtask

  // Keep valid up through a burst; drop it for a random gap between bursts.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      req_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly aim taps near the image so the inside path gets real traffic.
  task automatic pick_request(output row_t r, output pos_t y, output pos_t x);
    longint kr, kc, ch, ky, kx, ih, iw;
    kr = effective_kernel(k_rows);
    kc = effective_kernel(k_cols);
    ih = effective_dim(img_h);
    iw = effective_dim(img_w);
    if ($urandom_range(0, 3) == 0) begin
      r = row_t'($urandom);
      y = pos_t'($urandom);
      x = pos_t'($urandom);
    end else begin
      ch = ($urandom_range(0, 15) == 0) ? $urandom_range(1000, 1030) : $urandom_range(0, 7);
      ky = $urandom_range(0, 32'(kr - 1));
      kx = $urandom_range(0, 32'(kc - 1));
      r = row_t'((ch * kr + ky) * kc + kx);
      if (stride_y == 0) y = pos_t'($urandom);
      else y = pos_t'($urandom_range(0, 32'(ih + pad_top + 2)) / stride_y);
      if (stride_x == 0) x = pos_t'($urandom);
      else x = pos_t'($urandom_range(0, 32'(iw + pad_left + 2)) / stride_x);
    end
  endtask

  // Receiver: switch between stall patterns after a random hold
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= (stall_phase % 5) != 0;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    tap_t got, want;
    if (out_valid_o && out_ready_i) begin
      got.index = source_index_o;
      got.pad   = is_padding_o;
      if (expected_taps.size() == 0) begin
        report_mismatch("unrequested result", got, '0);
      end else begin
        want = expected_taps.pop_front();
        if (got.index !== want.index) report_mismatch("source_index", got, want);
        if (got.pad !== want.pad) report_mismatch("is_padding", got, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchdogLimit) begin
      $display("im2col_gather_address: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    reg_set_t vals;
    row_t     r;
    pos_t     y, x;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].set != active_set) begin
        settle();
        load_registers(reg_sets[directed[i].set]);
        active_set = directed[i].set;
      end
      send_request(directed[i].row, directed[i].y, directed[i].x, directed[i].typed,
                   directed[i].want);
      pace_sender();
    end

    for (int p = 0; p < RandomPhases; p++) begin
      settle();
      vals[CfgImageHeight] = pick_value(1, 4096, DimW);
      vals[CfgImageWidth]  = pick_value(1, 4096, DimW);
      vals[CfgKernelRows]  = pick_value(1, 16, KernW);
      vals[CfgKernelCols]  = pick_value(1, 16, KernW);
      vals[CfgRowStride]   = pick_value(1, 16, StrW);
      vals[CfgColStride]   = pick_value(1, 16, StrW);
      vals[CfgPadTop]      = pick_value(0, 15, PadW);
      vals[CfgPadLeft]     = pick_value(0, 15, PadW);
      load_registers(vals);
      for (int n = 0; n < PhaseRequests; n++) begin
        pick_request(r, y, x);
        send_request(r, y, x, 1'b0, '0);
        pace_sender();
        // hold off now and then until the pipeline runs dry
        if ($urandom_range(0, 199) == 0) settle();
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("im2col_gather_address: match");
    end else begin
      $display("im2col_gather_address: mismatch");
    end
    $finish;
  end

endmodule
